### rtl/core/ghs_pkg.sv
// Shared constants, codes and controller/datapath bundles for the histogram smoother.
package ghs_pkg;

  localparam int NUM_BINS      = 256;
  localparam int BIN_BITS      = 8;
  localparam int WIN_BITS      = 8;
  localparam int COUNT_BITS    = 32;
  localparam int TOTAL_BITS    = 32;
  localparam int FRACTION_BITS = 24;
  localparam int FRAC_W        = FRACTION_BITS + 1;
  localparam int SMOOTH_SHIFT  = 8;
  localparam int RUN_BITS      = COUNT_BITS + BIN_BITS;
  localparam int SM_BITS       = RUN_BITS + SMOOTH_SHIFT;
  localparam int PRE_BITS      = SM_BITS + BIN_BITS;
  localparam int STEP_BITS     = $clog2(SM_BITS + 1);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};
  localparam logic [FRAC_W-1:0]     FRAC_ONE  = {1'b1, {FRACTION_BITS{1'b0}}};

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_FINISH = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_STALE = 2'd2
  } status_t;

  localparam logic RK_FINISH = 1'b0;
  localparam logic RK_READ   = 1'b1;

  typedef struct packed {
    logic accept;
    logic add_wr;
    logic cnt_rd_loop;
    logic run_wr;
    logic loop_clr;
    logic loop_inc;
    logic run_rd_hi;
    logic run_rd_lo;
    logic cap_hi;
    logic div_sm;
    logic div_bin;
    logic div_cum;
    logic cap_bin;
    logic cap_cum;
    logic sm_wr;
    logic resp_read;
    logic resp_finish;
  } ghs_cmd_t;

  typedef struct packed {
    logic tables_ok;
    logic div_done;
    logic loop_last;
    logic out_busy;
  } ghs_sts_t;

endpackage

### rtl/core/ghs_if.sv
// Channel interfaces for the histogram smoother: request input, result output, configuration.
interface ghs_in_if;
  import ghs_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          op;
  logic [BIN_BITS-1:0] grey_level;
  logic [BIN_BITS-1:0] bin_index;
  modport source(output valid, op, grey_level, bin_index, input ready);
  modport sink(input valid, op, grey_level, bin_index, output ready);
endinterface

interface ghs_out_if;
  import ghs_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  reply_kind;
  logic [BIN_BITS-1:0]   bin_level;
  logic [COUNT_BITS-1:0] bin_count;
  logic [FRAC_W-1:0]     bin_fraction;
  logic [FRAC_W-1:0]     cumulative_fraction;
  logic [TOTAL_BITS-1:0] total_count;
  logic [1:0]            status;
  modport source(output valid, reply_kind, bin_level, bin_count, bin_fraction,
                 cumulative_fraction, total_count, status, input ready);
  modport sink(input valid, reply_kind, bin_level, bin_count, bin_fraction,
               cumulative_fraction, total_count, status, output ready);
endinterface

interface ghs_cfg_if;
  import ghs_pkg::*;
  logic                valid;
  logic                ready;
  logic [WIN_BITS-1:0] smoothing_window;
  modport source(output valid, smoothing_window, input ready);
  modport sink(input valid, smoothing_window, output ready);
endinterface

### rtl/core/ghs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ghs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/ghs_div.sv
// Restoring divider, one quotient bit per cycle, with a preloadable partial remainder.
module ghs_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [ghs_pkg::PRE_BITS-1:0]     rem_init,
  input  logic [ghs_pkg::SM_BITS-1:0]      num,
  input  logic [ghs_pkg::PRE_BITS-1:0]     dvs,
  input  logic [ghs_pkg::STEP_BITS-1:0]    steps,
  output logic                             done,
  output logic [ghs_pkg::SM_BITS-1:0]      quo
);
  import ghs_pkg::*;

  logic [PRE_BITS-1:0]  rem_r, dvs_r;
  logic [SM_BITS-1:0]   num_r, quo_r;
  logic [STEP_BITS-1:0] cnt_r;
  logic                 busy_r, done_r;
  logic [PRE_BITS:0]    trial, diff;
  logic                 ge;

  // Shift in the next numerator bit and subtract when the divisor fits.
  assign trial = {rem_r, num_r[SM_BITS-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= (steps != '0);
        cnt_r  <= steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == STEP_BITS'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= rem_init;
      num_r <= num;
      dvs_r <= dvs;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[PRE_BITS-1:0] : trial[PRE_BITS-1:0];
      num_r <= {num_r[SM_BITS-2:0], 1'b0};
      quo_r <= {quo_r[SM_BITS-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

### rtl/core/ghs_datapath.sv
// Datapath: bin count, running sum, smoothed and prefix memories, divider and result register.
module ghs_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ghs_pkg::ghs_cmd_t             cmd,
  output ghs_pkg::ghs_sts_t             sts,
  input  ghs_pkg::op_t                  in_op,
  input  logic [ghs_pkg::BIN_BITS-1:0]  in_grey_level,
  input  logic [ghs_pkg::BIN_BITS-1:0]  in_bin_index,
  input  logic                          cfg_valid,
  input  logic [ghs_pkg::WIN_BITS-1:0]  cfg_smoothing_window,
  output logic                          cfg_ready,
  ghs_out_if.source                     out_chan
);
  import ghs_pkg::*;

  // Configuration and global state
  logic [WIN_BITS-1:0]   win_r;
  logic [TOTAL_BITS-1:0] voxel_r;
  logic [PRE_BITS-1:0]   total_r, acc_r;
  logic                  ready_r;
  logic [NUM_BINS-1:0]   vld_r;
  logic [BIN_BITS-1:0]   loop_r, addr_r, cnt_raddr_r;
  logic [RUN_BITS-1:0]   hi_val_r;
  logic [FRAC_W-1:0]     bin_frac_r, cum_frac_r;

  // Memory ports
  logic                  cnt_re, cnt_we, run_re;
  logic [BIN_BITS-1:0]   cnt_raddr, run_raddr;
  logic [COUNT_BITS-1:0] cnt_q, cnt_val;
  logic [RUN_BITS-1:0]   run_q, run_sum, diff;
  logic [SM_BITS-1:0]    sm_q;
  logic [PRE_BITS-1:0]   pre_q, pre_sum;

  // Window decode
  logic [WIN_BITS-1:0]   w_eff, width, m;
  logic [6:0]            half;
  logic [BIN_BITS:0]     hi_sum, dbl;
  logic                  edge_lo, edge_hi;
  logic [BIN_BITS-1:0]   lo, hi, lo_m1;

  // Divider
  logic                  div_start, div_done;
  logic [PRE_BITS-1:0]   div_rem, div_dvs;
  logic [SM_BITS-1:0]    div_num, div_quo;
  logic [STEP_BITS-1:0]  div_steps;
  logic                  sm_ge, pre_ge, tables_ok;

  // Output register
  logic                  out_valid_r;
  logic                  kind_r;
  logic [BIN_BITS-1:0]   level_r;
  logic [COUNT_BITS-1:0] count_r;
  logic [FRAC_W-1:0]     ofrac_r, ocum_r;
  logic [TOTAL_BITS-1:0] ototal_r;
  status_t               ostatus_r;

  assign cfg_ready = 1'b1;
  assign tables_ok = ready_r && (total_r != '0);

  // Count memory: read at request time for add and read, or by the loop counter.
  assign cnt_re    = cmd.accept | cmd.cnt_rd_loop;
  assign cnt_raddr = cmd.accept ? ((in_op == OP_READ) ? in_bin_index : in_grey_level) : loop_r;
  assign cnt_val   = vld_r[cnt_raddr_r] ? cnt_q : '0;
  assign cnt_we    = cmd.add_wr && (cnt_val != COUNT_MAX);

  ghs_ram #(.WIDTH(COUNT_BITS), .DEPTH(NUM_BINS)) u_cnt_ram (
    .clk(clk), .we(cnt_we), .waddr(cnt_raddr_r), .wdata(cnt_val + 1'b1),
    .re(cnt_re), .raddr(cnt_raddr), .rdata(cnt_q)
  );

  // Centered window, shrunk symmetrically near both ends.
  assign w_eff   = win_r[0] ? win_r : ((win_r == '0) ? WIN_BITS'(1) : win_r - 1'b1);
  assign half    = w_eff[7:1];
  assign hi_sum  = {1'b0, loop_r} + {2'b0, half};
  assign dbl     = {loop_r, 1'b0};
  assign m       = ~loop_r;
  assign edge_lo = {1'b0, loop_r} < {2'b0, half};
  assign edge_hi = hi_sum[BIN_BITS];

  always_comb begin
    if (edge_lo) begin
      lo    = '0;
      hi    = dbl[BIN_BITS-1:0];
      width = {loop_r[6:0], 1'b1};
    end else if (edge_hi) begin
      lo    = BIN_BITS'(dbl - 9'd255);
      hi    = '1;
      width = {m[6:0], 1'b1};
    end else begin
      lo    = loop_r - {1'b0, half};
      hi    = hi_sum[BIN_BITS-1:0];
      width = w_eff;
    end
  end
  assign lo_m1 = lo - 1'b1;

  // Running sum memory holds the sum of counts up to and including each bin.
  assign run_sum   = acc_r[RUN_BITS-1:0] + RUN_BITS'(cnt_val);
  assign run_re    = cmd.run_rd_hi | cmd.run_rd_lo;
  assign run_raddr = cmd.run_rd_hi ? hi : lo_m1;
  assign diff      = hi_val_r - ((lo == '0) ? '0 : run_q);

  ghs_ram #(.WIDTH(RUN_BITS), .DEPTH(NUM_BINS)) u_run_ram (
    .clk(clk), .we(cmd.run_wr), .waddr(loop_r), .wdata(run_sum),
    .re(run_re), .raddr(run_raddr), .rdata(run_q)
  );

  assign pre_sum = acc_r + PRE_BITS'(div_quo);

  ghs_ram #(.WIDTH(SM_BITS), .DEPTH(NUM_BINS)) u_sm_ram (
    .clk(clk), .we(cmd.sm_wr), .waddr(loop_r), .wdata(div_quo),
    .re(cmd.accept), .raddr(in_bin_index), .rdata(sm_q)
  );

  ghs_ram #(.WIDTH(PRE_BITS), .DEPTH(NUM_BINS)) u_pre_ram (
    .clk(clk), .we(cmd.sm_wr), .waddr(loop_r), .wdata(pre_sum),
    .re(cmd.accept), .raddr(in_bin_index), .rdata(pre_q)
  );

  // The divider serves both the window average and the two fraction divisions.
  assign div_start = cmd.div_sm | cmd.div_bin | cmd.div_cum;
  always_comb begin
    if (cmd.div_sm) begin
      div_rem   = '0;
      div_num   = {diff, {SMOOTH_SHIFT{1'b0}}};
      div_dvs   = PRE_BITS'(width);
      div_steps = STEP_BITS'(SM_BITS);
    end else begin
      div_rem   = cmd.div_cum ? pre_q : PRE_BITS'(sm_q);
      div_num   = '0;
      div_dvs   = total_r;
      div_steps = STEP_BITS'(FRACTION_BITS);
    end
  end

  ghs_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .rem_init(div_rem), .num(div_num),
    .dvs(div_dvs), .steps(div_steps), .done(div_done), .quo(div_quo)
  );

  assign sm_ge  = PRE_BITS'(sm_q) >= total_r;
  assign pre_ge = pre_q >= total_r;

  assign sts.tables_ok = tables_ok;
  assign sts.div_done  = div_done;
  assign sts.loop_last = &loop_r;
  assign sts.out_busy  = out_valid_r && !out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r       <= WIN_BITS'(1);
      voxel_r     <= '0;
      total_r     <= '0;
      ready_r     <= 1'b0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        win_r   <= cfg_smoothing_window;
        ready_r <= 1'b0;
      end
      if (cmd.accept && (in_op == OP_CLEAR)) begin
        vld_r   <= '0;
        voxel_r <= '0;
        ready_r <= 1'b0;
      end
      if (cmd.add_wr) begin
        vld_r[cnt_raddr_r] <= 1'b1;
        ready_r            <= 1'b0;
        if (voxel_r != TOTAL_MAX) begin
          voxel_r <= voxel_r + 1'b1;
        end
      end
      if (cmd.resp_finish) begin
        total_r <= acc_r;
        ready_r <= 1'b1;
      end
      if (cmd.resp_read || cmd.resp_finish) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      addr_r <= in_bin_index;
    end
    if (cnt_re) begin
      cnt_raddr_r <= cnt_raddr;
    end
    if (cmd.loop_clr || cmd.accept) begin
      loop_r <= '0;
    end else if (cmd.loop_inc) begin
      loop_r <= loop_r + 1'b1;
    end
    if (cmd.loop_clr || cmd.accept) begin
      acc_r <= '0;
    end else if (cmd.run_wr) begin
      acc_r <= PRE_BITS'(run_sum);
    end else if (cmd.sm_wr) begin
      acc_r <= pre_sum;
    end
    if (cmd.cap_hi) begin
      hi_val_r <= run_q;
    end
    if (cmd.cap_bin) begin
      bin_frac_r <= sm_ge ? FRAC_ONE : {1'b0, div_quo[FRACTION_BITS-1:0]};
    end
    if (cmd.cap_cum) begin
      cum_frac_r <= pre_ge ? FRAC_ONE : {1'b0, div_quo[FRACTION_BITS-1:0]};
    end
    if (cmd.resp_read) begin
      kind_r   <= RK_READ;
      level_r  <= addr_r;
      count_r  <= cnt_val;
      ofrac_r  <= tables_ok ? bin_frac_r : '0;
      ocum_r   <= tables_ok ? cum_frac_r : '0;
      ototal_r <= voxel_r;
      if (!ready_r) begin
        ostatus_r <= ST_STALE;
      end else if (total_r == '0) begin
        ostatus_r <= ST_EMPTY;
      end else begin
        ostatus_r <= ST_OK;
      end
    end else if (cmd.resp_finish) begin
      kind_r    <= RK_FINISH;
      level_r   <= '0;
      count_r   <= '0;
      ofrac_r   <= '0;
      ocum_r    <= (acc_r != '0) ? FRAC_ONE : '0;
      ototal_r  <= voxel_r;
      ostatus_r <= (acc_r != '0) ? ST_OK : ST_EMPTY;
    end
  end

  assign out_chan.valid               = out_valid_r;
  assign out_chan.reply_kind          = kind_r;
  assign out_chan.bin_level           = level_r;
  assign out_chan.bin_count           = count_r;
  assign out_chan.bin_fraction        = ofrac_r;
  assign out_chan.cumulative_fraction = ocum_r;
  assign out_chan.total_count         = ototal_r;
  assign out_chan.status              = ostatus_r;

endmodule

### rtl/core/ghs_ctrl.sv
// Controller state machine sequencing adds, clears, reads and the finish passes.
module ghs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  ghs_pkg::op_t      in_op,
  output logic              in_ready,
  input  ghs_pkg::ghs_sts_t sts,
  output ghs_pkg::ghs_cmd_t cmd
);
  import ghs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_ADD_WR, S_RD_CHK, S_RD_BIN, S_RD_CUM, S_RD_RESP,
    S_RUN_RD, S_RUN_WR, S_SM_RDH, S_SM_RDL, S_SM_DIV, S_SM_WAIT, S_FIN_RESP
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          case (in_op)
            OP_ADD:    state_nxt = S_ADD_WR;
            OP_FINISH: state_nxt = S_RUN_RD;
            OP_READ:   state_nxt = S_RD_CHK;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_ADD_WR: begin
        cmd.add_wr = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_RD_CHK: begin
        if (sts.tables_ok) begin
          cmd.div_bin = 1'b1;
          state_nxt   = S_RD_BIN;
        end else begin
          state_nxt = S_RD_RESP;
        end
      end
      S_RD_BIN: begin
        if (sts.div_done) begin
          cmd.cap_bin = 1'b1;
          cmd.div_cum = 1'b1;
          state_nxt   = S_RD_CUM;
        end
      end
      S_RD_CUM: begin
        if (sts.div_done) begin
          cmd.cap_cum = 1'b1;
          state_nxt   = S_RD_RESP;
        end
      end
      S_RD_RESP: begin
        if (!sts.out_busy) begin
          cmd.resp_read = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_RUN_RD: begin
        cmd.cnt_rd_loop = 1'b1;
        state_nxt       = S_RUN_WR;
      end
      S_RUN_WR: begin
        cmd.run_wr = 1'b1;
        if (sts.loop_last) begin
          cmd.loop_clr = 1'b1;
          state_nxt    = S_SM_RDH;
        end else begin
          cmd.loop_inc = 1'b1;
          state_nxt    = S_RUN_RD;
        end
      end
      S_SM_RDH: begin
        cmd.run_rd_hi = 1'b1;
        state_nxt     = S_SM_RDL;
      end
      S_SM_RDL: begin
        cmd.cap_hi    = 1'b1;
        cmd.run_rd_lo = 1'b1;
        state_nxt     = S_SM_DIV;
      end
      S_SM_DIV: begin
        cmd.div_sm = 1'b1;
        state_nxt  = S_SM_WAIT;
      end
      S_SM_WAIT: begin
        if (sts.div_done) begin
          cmd.sm_wr = 1'b1;
          if (sts.loop_last) begin
            state_nxt = S_FIN_RESP;
          end else begin
            cmd.loop_inc = 1'b1;
            state_nxt    = S_SM_RDH;
          end
        end
      end
      S_FIN_RESP: begin
        if (!sts.out_busy) begin
          cmd.resp_finish = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/core/greylevel_histogram_smoother.sv
// Top level of the grey-level histogram with moving-average smoothing and cumulative table.
//
//   Channel   Dir  Handshake     Payload
//   in_chan   in   valid/ready   op, grey_level, bin_index
//   out_chan  out  valid/ready   reply_kind, bin_level, bin_count, bin_fraction,
//                                cumulative_fraction, total_count, status
//   cfg_chan  in   valid/ready   smoothing_window
//
// An add reads the count memory, then writes it back; a clear completes on acceptance.
// A read with stale or empty tables goes from its table check to its response; otherwise it
// runs two 24-step divisions in the shared restoring divider, for the bin and cumulative fractions.
// A finish makes one pass over the bins for the running sum, then a second pass for
// the window average, which runs 48 divider steps per bin.
// Reset clears the bin valid flags at once, so there is no clearing pass.
// A finished result waits in the output register while the next request is taken.
module greylevel_histogram_smoother (
  input logic        clk,
  input logic        rst_n,
  ghs_in_if.sink     in_chan,
  ghs_out_if.source  out_chan,
  ghs_cfg_if.sink    cfg_chan
);
  import ghs_pkg::*;

  ghs_cmd_t cmd;
  ghs_sts_t sts;
  op_t      in_op;

  assign in_op = op_t'(in_chan.op);

  ghs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_chan.valid), .in_op(in_op),
    .in_ready(in_chan.ready), .sts(sts), .cmd(cmd)
  );

  ghs_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .in_op(in_op),
    .in_grey_level(in_chan.grey_level), .in_bin_index(in_chan.bin_index),
    .cfg_valid(cfg_chan.valid), .cfg_smoothing_window(cfg_chan.smoothing_window),
    .cfg_ready(cfg_chan.ready), .out_chan(out_chan)
  );

  a_finish_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.reply_kind == RK_FINISH) |->
      (out_chan.bin_fraction == '0 && out_chan.bin_count == '0))
    else $error("finish summary carries bin data");

  a_cum_ge_bin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.status == ST_OK && out_chan.reply_kind == RK_READ) |->
      (out_chan.cumulative_fraction >= out_chan.bin_fraction &&
       out_chan.cumulative_fraction <= FRAC_ONE))
    else $error("cumulative fraction out of order");

  a_stale_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.status != ST_OK) |->
      (out_chan.bin_fraction == '0 && out_chan.cumulative_fraction == '0))
    else $error("fractions reported without valid tables");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (sts.div_done || cmd.run_wr) |-> !in_chan.ready)
    else $error("request accepted during a multi-cycle operation");

endmodule

### tb/tb_greylevel_histogram_smoother.sv
// Self-checking testbench for the grey-level histogram smoother.
module tb_greylevel_histogram_smoother;
  timeunit 1ns;
  timeprecision 1ps;
  import ghs_pkg::*;

  typedef struct packed {
    logic                  reply_kind;
    logic [BIN_BITS-1:0]   bin_level;
    logic [COUNT_BITS-1:0] bin_count;
    logic [FRAC_W-1:0]     bin_fraction;
    logic [FRAC_W-1:0]     cumulative_fraction;
    logic [TOTAL_BITS-1:0] total_count;
    status_t               status;
  } hist_reply_t;

  typedef struct {
    op_t           op;
    logic [7:0]    grey;
    logic [7:0]    idx;
    bit            typed;
    hist_reply_t   reply;
  } stim_row_t;

  localparam int WATCHDOG_LIMIT = 200000;
  localparam int SETTLE_CYCLES  = 20;
  localparam int ITEM_TARGET    = 1050;

  logic clk;
  logic rst_n;
  ghs_in_if  in_chan();
  ghs_out_if out_chan();
  ghs_cfg_if cfg_chan();

  greylevel_histogram_smoother i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  // Histogram state mirrored by the testbench.
  logic [COUNT_BITS-1:0] hist_bins [NUM_BINS];
  logic [63:0]           avg_bins [NUM_BINS];
  logic [63:0]           cum_bins [NUM_BINS];
  logic [TOTAL_BITS-1:0] voxel_sum;
  logic [63:0]           avg_sum;
  bit                    tables_valid;
  logic [WIN_BITS-1:0]   window_reg;

  hist_reply_t pending_replies[$];
  stim_row_t   directed_rows[$];
  int          mismatches;
  int          items_sent;
  int          tx_idle_pct;
  int          rx_idle_pct;
  int          quiet_cycles;

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic logic [FRAC_W-1:0] share_q24(logic [63:0] a, logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = 0;
    r = a;
    if (a >= d) return FRAC_ONE;
    for (int i = 0; i < FRACTION_BITS; i++) begin
      q = q << 1;
      if (r >= d - r) begin
        r = r - (d - r);
        q = q | 64'd1;
      end else begin
        r = r << 1;
      end
    end
    return q[FRAC_W-1:0];
  endfunction

  task automatic build_tables();
    logic [63:0] run [NUM_BINS+1];
    logic [63:0] w;
    logic [63:0] half;
    logic [63:0] acc;
    logic [63:0] width;
    int          lo;
    int          hi;
    int          m;
    w = window_reg;
    if (w[0] == 1'b0) w = (w == 0) ? 64'd1 : w - 64'd1;
    half = (w - 1) / 2;
    run[0] = 0;
    acc = 0;
    for (int l = 0; l < NUM_BINS; l++) run[l+1] = run[l] + hist_bins[l];
    for (int l = 0; l < NUM_BINS; l++) begin
      if (l < half) begin
        lo = 0;
        hi = 2 * l;
        width = 2 * l + 1;
      end else if (l >= NUM_BINS - half) begin
        m = NUM_BINS - 1 - l;
        lo = l - m;
        hi = NUM_BINS - 1;
        width = 2 * m + 1;
      end else begin
        lo = l - int'(half);
        hi = l + int'(half);
        width = w;
      end
      avg_bins[l] = ((run[hi+1] - run[lo]) * 256) / width;
      acc = acc + avg_bins[l];
      cum_bins[l] = acc;
    end
    avg_sum = acc;
    tables_valid = 1;
  endtask

  task automatic predict_reply(input op_t op, input logic [7:0] g, input logic [7:0] b,
                               output bit has_reply, output hist_reply_t r);
    has_reply = 0;
    r = '0;
    case (op)
      OP_ADD: begin
        if (hist_bins[g] != COUNT_MAX) hist_bins[g]++;
        if (voxel_sum != TOTAL_MAX) voxel_sum++;
        tables_valid = 0;
      end
      OP_CLEAR: begin
        foreach (hist_bins[l]) hist_bins[l] = '0;
        voxel_sum = '0;
        tables_valid = 0;
      end
      OP_FINISH: begin
        build_tables();
        has_reply = 1;
        r.reply_kind = RK_FINISH;
        r.cumulative_fraction = (avg_sum != 0) ? FRAC_ONE : '0;
        r.total_count = voxel_sum;
        r.status = (avg_sum != 0) ? ST_OK : ST_EMPTY;
      end
      default: begin
        has_reply = 1;
        r.reply_kind = RK_READ;
        r.bin_level = b;
        r.bin_count = hist_bins[b];
        r.total_count = voxel_sum;
        if (!tables_valid) begin
          r.status = ST_STALE;
        end else if (avg_sum == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.bin_fraction = share_q24(avg_bins[b], avg_sum);
          r.cumulative_fraction = share_q24(cum_bins[b], avg_sum);
          r.status = ST_OK;
        end
      end
    endcase
  endtask

  task automatic send_request(op_t op, logic [7:0] g, logic [7:0] b);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.op         <= op;
    in_chan.grey_level <= g;
    in_chan.bin_index  <= b;
    do @(posedge clk); while (!in_chan.ready);
    items_sent++;
    tx_idle_pct = (items_sent < 350) ? 14 : (items_sent < 700) ? 49 : 0;
    rx_idle_pct = (items_sent < 350) ? 49 : (items_sent < 700) ? 14 : 0;
  endtask

  task automatic issue(op_t op, logic [7:0] g, logic [7:0] b);
    bit          has_reply;
    hist_reply_t r;
    send_request(op, g, b);
    predict_reply(op, g, b, has_reply, r);
    if (has_reply) pending_replies.insert(pending_replies.size(), r);
  endtask

  // Adds and clears give no reply, so allow the last one to retire after the queue drains.
  task automatic settle();
    in_chan.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(logic [WIN_BITS-1:0] w);
    settle();
    cfg_chan.valid            <= 1'b1;
    cfg_chan.smoothing_window <= w;
    do @(posedge clk); while (!cfg_chan.ready);
    cfg_chan.valid <= 1'b0;
    window_reg = w;
    tables_valid = 0;
  endtask

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, field, got, want);
    mismatches++;
  endtask

  task automatic add_row(op_t op, logic [7:0] g, logic [7:0] b, bit typed, hist_reply_t r);
    stim_row_t row;
    row.op = op;
    row.grey = g;
    row.idx = b;
    row.typed = typed;
    row.reply = r;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  // Receiver: random back-pressure and reply checking.
  always @(posedge clk) begin
    hist_reply_t want;
    out_chan.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("unexpected reply", 1, 0);
      end else begin
        want = pending_replies.pop_front();
        if (out_chan.reply_kind !== want.reply_kind)
          report_mismatch("reply_kind", out_chan.reply_kind, want.reply_kind);
        if (out_chan.bin_level !== want.bin_level)
          report_mismatch("bin_level", out_chan.bin_level, want.bin_level);
        if (out_chan.bin_count !== want.bin_count)
          report_mismatch("bin_count", out_chan.bin_count, want.bin_count);
        if (out_chan.bin_fraction !== want.bin_fraction)
          report_mismatch("bin_fraction", out_chan.bin_fraction, want.bin_fraction);
        if (out_chan.cumulative_fraction !== want.cumulative_fraction)
          report_mismatch("cumulative_fraction", out_chan.cumulative_fraction,
                          want.cumulative_fraction);
        if (out_chan.total_count !== want.total_count)
          report_mismatch("total_count", out_chan.total_count, want.total_count);
        if (out_chan.status !== want.status)
          report_mismatch("status", out_chan.status, want.status);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
        (cfg_chan.valid && cfg_chan.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    logic [WIN_BITS-1:0] windows [$];
    logic [7:0]          center;
    bit                  has_reply;
    hist_reply_t         r;
    int                  phase;
    int                  phase_start;

    mismatches = 0;
    items_sent = 0;
    quiet_cycles = 0;
    tx_idle_pct = 14;
    rx_idle_pct = 49;
    foreach (hist_bins[l]) hist_bins[l] = '0;
    voxel_sum = '0;
    avg_sum = '0;
    tables_valid = 0;
    window_reg = 1;
    rst_n <= 1'b0;
    in_chan.valid <= 1'b0;
    in_chan.op <= OP_ADD;
    in_chan.grey_level <= '0;
    in_chan.bin_index <= '0;
    cfg_chan.valid <= 1'b0;
    cfg_chan.smoothing_window <= 8'd1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty and stale status, extremes of level and index, clear.
    add_row(OP_READ, 0, 0, 1, '{RK_READ, 0, 0, 0, 0, 0, ST_STALE});
    add_row(OP_FINISH, 0, 0, 1, '{RK_FINISH, 0, 0, 0, 0, 0, ST_EMPTY});
    add_row(OP_READ, 0, 255, 1, '{RK_READ, 255, 0, 0, 0, 0, ST_EMPTY});
    add_row(OP_ADD, 0, 0, 0, '0);
    add_row(OP_ADD, 255, 0, 0, '0);
    add_row(OP_ADD, 255, 0, 0, '0);
    add_row(OP_READ, 0, 255, 1, '{RK_READ, 255, 2, 0, 0, 3, ST_STALE});
    add_row(OP_FINISH, 0, 0, 1, '{RK_FINISH, 0, 0, 0, FRAC_ONE, 3, ST_OK});
    add_row(OP_READ, 0, 0, 0, '0);
    add_row(OP_READ, 0, 255, 0, '0);
    add_row(OP_READ, 0, 128, 0, '0);
    add_row(OP_CLEAR, 0, 0, 0, '0);
    add_row(OP_READ, 0, 7, 1, '{RK_READ, 7, 0, 0, 0, 0, ST_STALE});
    add_row(OP_FINISH, 0, 0, 1, '{RK_FINISH, 0, 0, 0, 0, 0, ST_EMPTY});
    add_row(OP_ADD, 128, 0, 0, '0);
    add_row(OP_FINISH, 0, 0, 0, '0);
    add_row(OP_READ, 0, 128, 0, '0);
    add_row(OP_READ, 0, 127, 0, '0);
    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].op, directed_rows[i].grey, directed_rows[i].idx);
      predict_reply(directed_rows[i].op, directed_rows[i].grey, directed_rows[i].idx,
                    has_reply, r);
      if (directed_rows[i].typed) r = directed_rows[i].reply;
      if (has_reply) pending_replies.insert(pending_replies.size(), r);
    end

    // Random: each phase uses one window setting, extremes and even widths included.
    windows = '{3, 255, 0, 2, 254, 7, 1, 17};
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      write_window((phase < windows.size()) ? windows[phase] : 8'($urandom_range(0, 255)));
      phase++;
      phase_start = items_sent;
      while (items_sent - phase_start < 120 && items_sent < ITEM_TARGET) begin
        if ($urandom_range(0, 3) == 0) issue(OP_CLEAR, 8'($urandom), 8'($urandom));
        center = 8'($urandom);
        repeat ($urandom_range(5, 40)) begin
          if ($urandom_range(0, 9) == 0) begin
            issue(op_t'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
          end else if ($urandom_range(0, 2) == 0) begin
            issue(OP_ADD, 8'($urandom), 8'd0);
          end else begin
            issue(OP_ADD, center + 8'($urandom_range(0, 6)) - 8'd3, 8'($urandom));
          end
        end
        if ($urandom_range(0, 5) != 0) issue(OP_FINISH, 8'($urandom), 8'($urandom));
        repeat ($urandom_range(3, 8)) begin
          case ($urandom_range(0, 3))
            0: issue(OP_READ, 8'($urandom), 8'd0);
            1: issue(OP_READ, 8'($urandom), 8'd255);
            default: issue(OP_READ, 8'($urandom), 8'($urandom));
          endcase
        end
      end
    end

    settle();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
